/* rtl/lrs_pkg.sv */
// ----------------------------------------------------------------------------
// lrs_pkg
// shared constants, types and register codes of the linear resampler
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_RUN     = 64;

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int STEP_W = 20;
  localparam int CHAN_W = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

  // register index, taken from paddr bit 2 (the word address bit)
  localparam logic REG_STEP     = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } lrs_state_t;

  // lane commands from the sequencer
  typedef struct packed {
    logic prev_from_in;
    logic prev_from_cur;
    logic cur_from_in;
    logic mul_en;
  } lrs_lane_ctl_t;

  // result load into the output register
  typedef struct packed {
    logic load;
    logic last;
  } lrs_emit_t;

endpackage

/* rtl/lrs_lane.sv */
// ----------------------------------------------------------------------------
// lrs_lane
// one channel lane: stored frame sample, new sample and interpolation product
// ----------------------------------------------------------------------------
module lrs_lane #(
  parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS,
  parameter int FRAC_BITS   = lrs_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  lrs_pkg::lrs_lane_ctl_t        ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [FRAC_BITS-1:0]   frac,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int PW = FRAC_BITS + SAMPLE_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] cur;
  logic signed [PW-1:0]          prod;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PW-1:0]          prod_next;
  logic signed [PW-1:0]          shifted;

  assign diff      = {cur[SAMPLE_BITS-1], cur} - {prev[SAMPLE_BITS-1], prev};
  assign frac_s    = {1'b0, frac};
  assign prod_next = frac_s * diff;
  // floor of the scaled difference, result stays between prev and cur
  assign shifted   = prod >>> FRAC_BITS;
  assign y         = prev + shifted[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ctl.prev_from_in) begin
      prev <= sample;
    end else if (ctl.prev_from_cur) begin
      prev <= cur;
    end
    if (ctl.cur_from_in) begin
      cur <= sample;
    end
    if (ctl.mul_en) begin
      prod <= prod_next;
    end
  end

endmodule

/* rtl/lrs_ctrl.sv */
// ----------------------------------------------------------------------------
// lrs_ctrl
// sequencer: read position, run count and lane commands for each frame
// ----------------------------------------------------------------------------
module lrs_ctrl #(
  parameter int FRAC_BITS = lrs_pkg::FRAC_BITS,
  parameter int MAX_RUN   = lrs_pkg::MAX_RUN
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          restart,
  input  logic                          out_free,
  input  logic [lrs_pkg::STEP_W-1:0]    step,
  output logic                          in_stall,
  output lrs_pkg::lrs_lane_ctl_t        lane_ctl,
  output lrs_pkg::lrs_emit_t            emit,
  output logic [FRAC_BITS-1:0]          frac
);

  localparam int POS_W    = ((FRAC_BITS > lrs_pkg::STEP_W) ? FRAC_BITS : lrs_pkg::STEP_W) + 1;
  localparam int ST_W     = POS_W - 1;
  localparam int CNT_W    = $clog2(MAX_RUN + 1);
  localparam int STEP_MIN = ((1 << FRAC_BITS) + MAX_RUN - 1) / MAX_RUN;

  localparam logic [POS_W-1:0] ONE_POS  = {{(POS_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [ST_W-1:0]  ST_MIN   = ST_W'(STEP_MIN);
  localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(MAX_RUN);

  lrs_pkg::lrs_state_t state, state_next;
  logic [POS_W-1:0] position, position_next;
  logic [CNT_W-1:0] count, count_next;
  logic             have_prev, have_prev_next;

  logic [ST_W-1:0]  step_ext;
  logic [ST_W-1:0]  st;
  logic [POS_W-1:0] pos_sum;
  logic [CNT_W-1:0] count_inc;
  logic             accept;
  logic             done;

  assign step_ext  = ST_W'(step);
  assign st        = (step_ext < ST_MIN) ? ST_MIN : step_ext;
  assign pos_sum   = position + POS_W'(st);
  assign count_inc = count + 1'b1;
  assign done      = (pos_sum >= ONE_POS) || (count_inc == RUN_LAST);
  assign frac      = position[FRAC_BITS-1:0];
  assign in_stall  = (state != lrs_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrs_pkg::ST_IDLE;
      position  <= '0;
      count     <= '0;
      have_prev <= 1'b0;
    end else begin
      state     <= state_next;
      position  <= position_next;
      count     <= count_next;
      have_prev <= have_prev_next;
    end
  end

  always_comb begin
    state_next     = state;
    position_next  = position;
    count_next     = count;
    have_prev_next = have_prev;
    lane_ctl       = '0;
    emit           = '0;
    case (state)
      lrs_pkg::ST_IDLE: begin
        if (accept) begin
          if (!have_prev || restart) begin
            // priming frame only fills the store
            lane_ctl.prev_from_in = 1'b1;
            have_prev_next        = 1'b1;
            if (restart) begin
              position_next = '0;
            end
          end else if (position >= ONE_POS) begin
            // frame with no result
            lane_ctl.prev_from_in = 1'b1;
            position_next         = position - ONE_POS;
          end else begin
            lane_ctl.cur_from_in = 1'b1;
            count_next           = '0;
            state_next           = lrs_pkg::ST_MUL;
          end
        end
      end
      lrs_pkg::ST_MUL: begin
        lane_ctl.mul_en = 1'b1;
        state_next      = lrs_pkg::ST_EMIT;
      end
      lrs_pkg::ST_EMIT: begin
        if (out_free) begin
          emit.load  = 1'b1;
          emit.last  = done;
          count_next = count_inc;
          if (done) begin
            position_next          = (pos_sum >= ONE_POS) ? pos_sum - ONE_POS : '0;
            lane_ctl.prev_from_cur = 1'b1;
            state_next             = lrs_pkg::ST_IDLE;
          end else begin
            position_next = pos_sum;
            state_next    = lrs_pkg::ST_MUL;
          end
        end
      end
      default: begin
        state_next = lrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/linear_interp_resampler.sv */
// ----------------------------------------------------------------------------
// linear_interp_resampler
// sample rate converter by linear interpolation, one or two channels
//
//   channel   signals                            direction
//   input     in_valid in_stall in_ch0/1 restart  frame in
//   output    out_valid out_stall out_ch0/1 last  interpolated frame out
//   config    psel penable pwrite paddr pwdata    step, channel_count
//
// a frame is taken in the idle state; each result then passes through the lane
// multipliers and then the output register load, and in_stall stays high until
// the run is over; priming frames and frames with no result stay in idle.
// rst clears the position, run control and output valid; the stored frame
// counts as empty until the first frame after reset or restart.
// a stalled output register holds the run in place until it is taken.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
  parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS,
  parameter int FRAC_BITS   = lrs_pkg::FRAC_BITS,
  parameter int MAX_RUN     = lrs_pkg::MAX_RUN
) (
  input  logic                          clk,
  input  logic                          rst,
  // input frames
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_ch0,
  input  logic signed [SAMPLE_BITS-1:0] in_ch1,
  input  logic                          restart,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_ch0,
  output logic signed [SAMPLE_BITS-1:0] out_ch1,
  output logic                          last,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrs_pkg::ADDR_W-1:0]    paddr,
  input  logic [lrs_pkg::DATA_W-1:0]    pwdata,
  output logic [lrs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [lrs_pkg::STEP_W-1:0] step;
  logic [lrs_pkg::CHAN_W-1:0] channel_count;
  logic                       stereo;
  logic                       cfg_wr;
  logic                       out_free;

  lrs_pkg::lrs_lane_ctl_t     lane_ctl;
  lrs_pkg::lrs_emit_t         emit;
  logic [FRAC_BITS-1:0]       frac;
  logic signed [SAMPLE_BITS-1:0] ch1_in;
  logic signed [SAMPLE_BITS-1:0] y0;
  logic signed [SAMPLE_BITS-1:0] y1;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign stereo = channel_count[1];
  // mono keeps the second lane at zero
  assign ch1_in = stereo ? in_ch1 : '0;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= lrs_pkg::STEP_RESET;
      channel_count <= lrs_pkg::CHAN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        lrs_pkg::REG_STEP:     step          <= pwdata[lrs_pkg::STEP_W-1:0];
        lrs_pkg::REG_CHANNELS: channel_count <= pwdata[lrs_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lrs_pkg::REG_STEP:     prdata = {{(lrs_pkg::DATA_W-lrs_pkg::STEP_W){1'b0}}, step};
      lrs_pkg::REG_CHANNELS: prdata = {{(lrs_pkg::DATA_W-lrs_pkg::CHAN_W){1'b0}},
                                       channel_count};
      default:               prdata = '0;
    endcase
  end

  lrs_ctrl #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_RUN   (MAX_RUN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .restart  (restart),
    .out_free (out_free),
    .step     (step),
    .in_stall (in_stall),
    .lane_ctl (lane_ctl),
    .emit     (emit),
    .frac     (frac)
  );

  lrs_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lane0 (
    .clk    (clk),
    .ctl    (lane_ctl),
    .sample (in_ch0),
    .frac   (frac),
    .y      (y0)
  );

  lrs_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lane1 (
    .clk    (clk),
    .ctl    (lane_ctl),
    .sample (ch1_in),
    .frac   (frac),
    .y      (y1)
  );

  // output valid: set on a result load, cleared once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // second lane may still hold a stereo sample on the first mono frame
  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_ch0 <= y0;
      out_ch1 <= stereo ? y1 : '0;
      last    <= emit.last;
    end
  end

endmodule

/* sim/tb_linear_interp_resampler.sv */
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler
// self-checking bench for the linear interpolation resampler: a scoreboard
// tracks stored frame, read position and register values, predicts every
// interpolated item and compares it with the block's output in order, while
// the register port walks through step and channel settings and both sides
// idle and stall at random
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler;
  import lrs_pkg::*;

  localparam int unsigned ONE_POS       = 1 << FRAC_BITS;
  localparam int unsigned STEP_FLOOR    = (ONE_POS + MAX_RUN - 1) / MAX_RUN;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_LIMIT   = 100000;

  typedef enum {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  class resample_scoreboard;
    typedef struct {
      logic signed [SAMPLE_BITS-1:0] ch0;
      logic signed [SAMPLE_BITS-1:0] ch1;
      logic                          last;
    } frame_t;

    frame_t                        expected_q[$];
    logic [STEP_W-1:0]             step_val = STEP_RESET;
    logic [CHAN_W-1:0]             chan_val = CHAN_RESET;
    logic signed [SAMPLE_BITS-1:0] prev0    = '0;
    logic signed [SAMPLE_BITS-1:0] prev1    = '0;
    int unsigned                   pos      = 0;
    bit                            primed   = 1'b0;
    int unsigned                   errors   = 0;
    int unsigned                   frames   = 0;
    int unsigned                   results  = 0;

    task report_mismatch(input string msg);
      errors++;
      if (errors <= 30) $display("mismatch: %s", msg);
    endtask

    function void write_config(logic idx, logic [DATA_W-1:0] value);
      if (idx == REG_STEP) step_val = value[STEP_W-1:0];
      else chan_val = value[CHAN_W-1:0];
    endfunction

    // prev + floor(frac * (new - prev) / one)
    function logic signed [SAMPLE_BITS-1:0] blend(logic signed [SAMPLE_BITS-1:0] a,
                                                 logic signed [SAMPLE_BITS-1:0] b,
                                                 int unsigned frac);
      longint diff;
      longint prod;
      diff = longint'(b) - longint'(a);
      prod = longint'(frac) * diff;
      return SAMPLE_BITS'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    function void note_frame(logic signed [SAMPLE_BITS-1:0] a,
                             logic signed [SAMPLE_BITS-1:0] b, logic rs);
      bit                            stereo;
      logic signed [SAMPLE_BITS-1:0] s0;
      logic signed [SAMPLE_BITS-1:0] s1;
      int unsigned                   st;
      int                            n;
      frame_t                        item;
      frames++;
      stereo = chan_val >= 2;
      s0 = a;
      s1 = stereo ? b : '0;
      st = (step_val < STEP_FLOOR) ? STEP_FLOOR : step_val;
      if (rs) begin
        prev0  = '0;
        prev1  = '0;
        pos    = 0;
        primed = 1'b0;
      end
      if (!primed) begin
        prev0  = s0;
        prev1  = s1;
        primed = 1'b1;
        return;
      end
      n = 0;
      while (pos < ONE_POS && n < MAX_RUN) begin
        item.ch0  = blend(prev0, s0, pos);
        item.ch1  = stereo ? blend(prev1, s1, pos) : '0;
        item.last = 1'b0;
        expected_q.push_back(item);
        n++;
        pos += st;
      end
      if (n > 0) expected_q[expected_q.size()-1].last = 1'b1;
      pos   = (pos >= ONE_POS) ? pos - ONE_POS : 0;
      prev0 = s0;
      prev1 = s1;
    endfunction

    task check_result(input logic signed [SAMPLE_BITS-1:0] ch0,
                      input logic signed [SAMPLE_BITS-1:0] ch1, input logic lst);
      frame_t want;
      results++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item ch0=%0d ch1=%0d last=%0b", ch0, ch1, lst));
        return;
      end
      want = expected_q.pop_front();
      if (ch0 !== want.ch0)
        report_mismatch($sformatf("item %0d out_ch0 %0d, want %0d", results, ch0, want.ch0));
      if (ch1 !== want.ch1)
        report_mismatch($sformatf("item %0d out_ch1 %0d, want %0d", results, ch1, want.ch1));
      if (lst !== want.last)
        report_mismatch($sformatf("item %0d last %0b, want %0b", results, lst, want.last));
    endtask
  endclass

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_ch0    = '0;
  logic signed [SAMPLE_BITS-1:0] in_ch1    = '0;
  logic                          restart   = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_ch0;
  logic signed [SAMPLE_BITS-1:0] out_ch1;
  logic                          last;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [ADDR_W-1:0]             paddr     = '0;
  logic [DATA_W-1:0]             pwdata    = '0;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;

  resample_scoreboard sb = new();
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  int unsigned settings = 0;

  linear_interp_resampler u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch0   (in_ch0),
    .in_ch1   (in_ch1),
    .restart  (restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ch0  (out_ch0),
    .out_ch1  (out_ch1),
    .last     (last),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_ch0, out_ch1, last);
  end

  // caller must send again or lower in_valid before time moves on
  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] a,
                            input logic signed [SAMPLE_BITS-1:0] b, input logic rs);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch0   <= a;
    in_ch1   <= b;
    restart  <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_frame(a, b, rs);
  endtask

  task automatic hold_until_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < DRAIN_LIMIT && sb.expected_q.size() != 0; w++) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_config(idx, value);
  endtask

  // registers change only once the block has gone quiet
  task automatic configure(input logic [DATA_W-1:0] step_word,
                           input logic [DATA_W-1:0] chan_word, input pace_t pace);
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_STEP, step_word);
    write_reg(REG_CHANNELS, chan_word);
    case (pace)
      PACE_FREE: begin
        send_pct = 0;
        recv_pct = 0;
      end
      PACE_SENDER: begin
        send_pct = 78;
        recv_pct = 0;
      end
      PACE_RECEIVER: begin
        send_pct = 0;
        recv_pct = 78;
      end
      default: begin
        send_pct = 31;
        recv_pct = 31;
      end
    endcase
    settings++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return SAMPLE_BITS'(int'($urandom_range(64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic random_frames(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 || $urandom_range(19) == 0) hold_until_empty();
      send_frame(pick_sample(), pick_sample(), $urandom_range(15) == 0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: unity step, stereo; first frame only primes
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    send_frame(16'sh8000, 16'sh7fff, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b0);

    // minimum step gives the longest run, full-scale swings
    configure(32'd1024, 32'd2, PACE_FREE);
    send_frame(16'sh8000, 16'sh7fff, 1'b0);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);

    // zero step saturates to the floor, mono
    configure(32'd0, 32'd1, PACE_FREE);
    send_frame(16'sh0001, 16'shffff, 1'b0);
    send_frame(16'sh8000, 16'sh7fff, 1'b0);

    // just below the floor, channel count zero, restart primes again
    configure(32'd1023, 32'd0, PACE_FREE);
    send_frame(16'sh0064, 16'sh00c8, 1'b1);
    send_frame(16'shff9c, 16'sh0005, 1'b0);

    // largest step, channel count three; most frames give nothing
    configure(32'h000f_ffff, 32'd3, PACE_FREE);
    for (int i = 0; i < 5; i++) send_frame(16'(5 + 2 * i), 16'(6 + 2 * i), 1'b0);

    // upper bits of the write data are dropped
    configure(32'hfff1_8000, 32'hffff_fffe, PACE_FREE);
    send_frame(16'sh4000, 16'shc000, 1'b1);
    send_frame(16'shc000, 16'sh4000, 1'b0);
    send_frame(16'sh7fff, 16'sh7fff, 1'b0);
    send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_frame(16'sh1234, 16'shedcb, 1'b0);

    configure(32'd65536, 32'd2, PACE_FREE);
    random_frames(12);
    configure(32'd21845, 32'd2, PACE_SENDER);
    random_frames(12);
    configure(32'd1024, 32'd1, PACE_RECEIVER);
    random_frames(6);
    configure(32'd98304, 32'd2, PACE_BOTH);
    random_frames(12);
    configure(32'd60211, 32'd3, PACE_FREE);
    random_frames(12);
    configure($urandom_range(200000, 1024), 32'd2, PACE_BOTH);
    random_frames(12);
    configure(32'd16384, 32'd0, PACE_SENDER);
    random_frames(12);
    configure(32'd131072, 32'd2, PACE_RECEIVER);
    random_frames(12);
    configure($urandom_range(2047), 32'd2, PACE_BOTH);
    random_frames(10);

    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d expected items never came", sb.expected_q.size()));

    $display("checked %0d output items from %0d frames over %0d register settings",
             sb.results, sb.frames, settings);
    $display("step from zero to maximum, mono and stereo, restarts, four pacing modes");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d items still expected", sb.expected_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
